FILE: rtl/scsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared types, constants and helper functions for the slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int POOL_BLOCKS = 32;
    localparam int BLK_W       = 5;
    localparam int BLOCK_LOG2  = 10;
    localparam int SLOTS_MAX   = 32;
    localparam int NUM_CLASSES = 3;
    localparam int RAM_W       = SLOTS_MAX + 6;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_WAIT    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    // Owner code of a block that no class has claimed.
    localparam logic [1:0] OWN_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_C0_LOG2 = 3'd0;
    localparam logic [2:0] CFG_C1_LOG2 = 3'd1;
    localparam logic [2:0] CFG_C2_LOG2 = 3'd2;
    localparam logic [2:0] CFG_C0_MAX  = 3'd3;
    localparam logic [2:0] CFG_C1_MAX  = 3'd4;
    localparam logic [2:0] CFG_C2_MAX  = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [10:0] request_size;
        logic        no_wait;
        logic [14:0] free_address;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] slot_address;
        logic [1:0]  size_class;
        logic        wake_waiters;
    } t_out_beat;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic cls_next;
        logic scan_init;
        logic scan_dec;
        logic scan_rd;
        logic claim;
        logic alloc_commit;
        logic fail;
        logic free_rd;
        logic free_commit;
        logic free_bad;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_free;
        logic cls_done;
        logic cls_fit;
        logic cf_zero;
        logic can_claim;
        logic scan_end;
        logic owner_match;
        logic blk_has_free;
        logic bit_found;
        logic free_owner_bad;
        logic free_slot_bad;
        logic free_bit_set;
    } t_dp_sts;

    // Clamp a size log2 into the supported range.
    function automatic logic [3:0] f_clamp(input logic [3:0] lg);
        logic [3:0] r;
        r = lg;
        if (lg < 4'd5) r = 4'd5;
        if (lg > 4'd10) r = 4'd10;
        return r;
    endfunction

    // Slots per block for a clamped log2, capped at the bitmap width.
    function automatic logic [5:0] f_slots(input logic [3:0] lg);
        logic [10:0] n;
        n = 11'd1024 >> lg;
        if (n > 11'(SLOTS_MAX)) n = 11'(SLOTS_MAX);
        return n[5:0];
    endfunction

endpackage

FILE: rtl/scsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_q;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/scsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Configuration, class counters, block owners, slot bitmap memory and the
// result register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module scsa_dp import scsa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [5:0] i_cfg_wdata,
    input  t_in_beat   i_data,
    output t_out_beat  o_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts
);

    logic [3:0]       r_lg  [0:NUM_CLASSES-1];
    logic [5:0]       r_max [0:NUM_CLASSES-1];
    logic [10:0]      r_cf  [0:NUM_CLASSES-1];
    logic [5:0]       r_cnt [0:NUM_CLASSES-1];
    logic [1:0]       r_owner [0:POOL_BLOCKS-1];
    logic [5:0]       r_next;
    logic             r_waiter;
    t_in_beat         r_req;
    logic [1:0]       r_cls;
    logic [5:0]       r_b;
    logic [BLK_W-1:0] r_blk;
    t_out_beat        r_out;

    logic [5:0]       bm1;
    logic [BLK_W-1:0] fblk;
    logic [BLK_W-1:0] own_addr;
    logic [1:0]       own;
    logic [1:0]       sel_cls;
    logic [3:0]       lg_raw;
    logic [3:0]       lg;
    logic [5:0]       n;
    logic [10:0]      cf_cur;
    logic [5:0]       cnt_cur;
    logic [5:0]       max_cur;
    logic [11:0]      cf_sum;
    logic [10:0]      cf_claim;
    logic [RAM_W-1:0] rd_word;
    logic [31:0]      rd_map;
    logic [5:0]       rd_free;
    logic [31:0]      mask;
    logic [31:0]      open_bits;
    logic [4:0]       j;
    logic [9:0]       fslot;
    logic [31:0]      fbit;
    logic             ram_we;
    logic [BLK_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [BLK_W-1:0] ram_raddr;

    assign bm1      = r_b - 6'd1;
    assign fblk     = r_req.free_address[14:10];
    assign own_addr = r_req.req_type ? fblk : bm1[BLK_W-1:0];
    assign own      = r_owner[own_addr];
    assign sel_cls  = r_req.req_type ? own : r_cls;

    // Per-class selection of configuration and counters.
    always_comb begin
        case (sel_cls)
            2'd1: begin
                lg_raw = r_lg[1]; max_cur = r_max[1]; cf_cur = r_cf[1]; cnt_cur = r_cnt[1];
            end
            2'd2: begin
                lg_raw = r_lg[2]; max_cur = r_max[2]; cf_cur = r_cf[2]; cnt_cur = r_cnt[2];
            end
            default: begin
                lg_raw = r_lg[0]; max_cur = r_max[0]; cf_cur = r_cf[0]; cnt_cur = r_cnt[0];
            end
        endcase
    end

    assign lg = f_clamp(lg_raw);
    assign n  = f_slots(lg);

    // Free count after claiming a block and taking its first slot.
    assign cf_sum   = {1'b0, cf_cur} + {6'd0, n};
    assign cf_claim = (cf_sum > 12'd2047) ? 11'd2046 : cf_sum[10:0] - 11'd1;

    // Lowest clear bit of the block bitmap within the slot count.
    assign rd_map    = rd_word[RAM_W-1:6];
    assign rd_free   = rd_word[5:0];
    assign mask      = (n >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
    assign open_bits = ~rd_map & mask;
    always_comb begin
        j = 5'd0;
        for (int k = 31; k >= 0; k--) begin
            if (open_bits[k]) j = 5'(k);
        end
    end

    assign fslot = r_req.free_address[9:0] >> lg;
    assign fbit  = 32'd1 << fslot[4:0];

    // Status toward the controller.
    always_comb begin
        o_sts.is_free        = r_req.req_type;
        o_sts.cls_done       = (r_cls == 2'(NUM_CLASSES));
        o_sts.cls_fit        = ((11'd1 << lg) >= r_req.request_size);
        o_sts.cf_zero        = (cf_cur == 11'd0);
        o_sts.can_claim      = (cnt_cur < max_cur) && (r_next < 6'(POOL_BLOCKS));
        o_sts.scan_end       = (r_b == 6'd0);
        o_sts.owner_match    = (own == r_cls);
        o_sts.blk_has_free   = (rd_free != 6'd0);
        o_sts.bit_found      = |open_bits;
        o_sts.free_owner_bad = (own == OWN_NONE);
        o_sts.free_slot_bad  = (fslot >= {4'd0, n});
        o_sts.free_bit_set   = |(rd_map & fbit);
    end

    // Bitmap memory access.
    always_comb begin
        ram_re    = i_cmd.scan_rd || i_cmd.free_rd;
        ram_raddr = i_cmd.free_rd ? fblk : bm1[BLK_W-1:0];
        ram_we    = i_cmd.claim || i_cmd.alloc_commit || i_cmd.free_commit;
        ram_waddr = r_blk;
        ram_wdata = {rd_map | (32'd1 << j), rd_free - 6'd1};
        if (i_cmd.claim) begin
            ram_waddr = r_next[BLK_W-1:0];
            ram_wdata = {32'd1, n - 6'd1};
        end else if (i_cmd.free_commit) begin
            ram_waddr = fblk;
            ram_wdata = {rd_map & ~fbit, (rd_free == 6'd63) ? rd_free : rd_free + 6'd1};
        end
    end

    scsa_ram #(.WIDTH(RAM_W), .DEPTH(POOL_BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_word)
    );

    // Request capture and scan pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_data;
        end
        if (i_cmd.scan_rd) begin
            r_blk <= bm1[BLK_W-1:0];
        end
        if (i_cmd.scan_init) begin
            r_b <= r_next;
        end else if (i_cmd.scan_dec || i_cmd.scan_rd) begin
            r_b <= bm1;
        end
    end

    // Control state: configuration, counters, owners, class pointer, waiter flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg[0]  <= 4'd5;
            r_lg[1]  <= 4'd7;
            r_lg[2]  <= 4'd9;
            r_max[0] <= 6'd2;
            r_max[1] <= 6'd6;
            r_max[2] <= 6'd24;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cf[k]  <= 11'd0;
                r_cnt[k] <= 6'd0;
            end
            for (int k = 0; k < POOL_BLOCKS; k++) begin
                r_owner[k] <= OWN_NONE;
            end
            r_next   <= 6'd0;
            r_waiter <= 1'b0;
            r_cls    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_C0_LOG2: r_lg[0]  <= i_cfg_wdata[3:0];
                    CFG_C1_LOG2: r_lg[1]  <= i_cfg_wdata[3:0];
                    CFG_C2_LOG2: r_lg[2]  <= i_cfg_wdata[3:0];
                    CFG_C0_MAX:  r_max[0] <= i_cfg_wdata;
                    CFG_C1_MAX:  r_max[1] <= i_cfg_wdata;
                    CFG_C2_MAX:  r_max[2] <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_cls <= 2'd0;
            end else if (i_cmd.cls_next) begin
                r_cls <= r_cls + 2'd1;
            end
            if (i_cmd.claim) begin
                r_owner[r_next[BLK_W-1:0]] <= r_cls;
                r_cf[r_cls]  <= cf_claim;
                r_cnt[r_cls] <= (cnt_cur == 6'd63) ? cnt_cur : cnt_cur + 6'd1;
                r_next       <= r_next + 6'd1;
            end
            if (i_cmd.alloc_commit && cf_cur != 11'd0) begin
                r_cf[r_cls] <= cf_cur - 11'd1;
            end
            if (i_cmd.free_commit) begin
                if (cf_cur != 11'd2047) begin
                    r_cf[sel_cls] <= cf_cur + 11'd1;
                end
                r_waiter <= 1'b0;
            end
            if (i_cmd.fail && !r_req.no_wait) begin
                r_waiter <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_out <= '{ST_OK, {r_next[BLK_W-1:0], 10'd0}, r_cls, 1'b0};
        end else if (i_cmd.alloc_commit) begin
            r_out <= '{ST_OK, {r_blk, 10'd0} | (15'(j) << lg), r_cls, 1'b0};
        end else if (i_cmd.fail) begin
            r_out <= '{r_req.no_wait ? ST_NOSPACE : ST_WAIT, 15'd0, 2'd0, 1'b0};
        end else if (i_cmd.free_commit) begin
            r_out <= '{ST_OK, r_req.free_address, own, r_waiter};
        end else if (i_cmd.free_bad) begin
            r_out <= '{ST_BADFREE, r_req.free_address,
                       (own == OWN_NONE) ? 2'd0 : own, 1'b0};
        end
    end

    assign o_data = r_out;

endmodule

FILE: rtl/scsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences class selection, block scan and free handling, and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module scsa_ctrl import scsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CLASS = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_FCHK  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       done;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = i_sts.is_free ? S_FREE : S_CLASS;
            end
            S_CLASS: begin
                if (out_free) begin
                    if (i_sts.cls_done) begin
                        o_cmd.fail = 1'b1;
                        n_state    = S_IDLE;
                    end else if (!i_sts.cls_fit) begin
                        o_cmd.cls_next = 1'b1;
                    end else if (i_sts.cf_zero) begin
                        if (i_sts.can_claim) begin
                            o_cmd.claim = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            o_cmd.cls_next = 1'b1;
                        end
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Walk blocks downward from the newest claimed one.
                if (i_sts.scan_end) begin
                    o_cmd.cls_next = 1'b1;
                    n_state        = S_CLASS;
                end else if (i_sts.owner_match) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_CHK;
                end else begin
                    o_cmd.scan_dec = 1'b1;
                end
            end
            S_CHK: begin
                if (out_free) begin
                    if (!i_sts.blk_has_free) begin
                        n_state = S_SCAN;
                    end else if (i_sts.bit_found) begin
                        o_cmd.alloc_commit = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        o_cmd.cls_next = 1'b1;
                        n_state        = S_CLASS;
                    end
                end
            end
            S_FREE: begin
                if (out_free) begin
                    if (i_sts.free_owner_bad || i_sts.free_slot_bad) begin
                        o_cmd.free_bad = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.free_rd = 1'b1;
                        n_state       = S_FCHK;
                    end
                end
            end
            S_FCHK: begin
                if (out_free) begin
                    o_cmd.free_commit = i_sts.free_bit_set;
                    o_cmd.free_bad    = !i_sts.free_bit_set;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign done = o_cmd.fail || o_cmd.claim || o_cmd.alloc_commit ||
                  o_cmd.free_commit || o_cmd.free_bad;

    // Result valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/size_class_slab_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class slab allocator core
// Allocates and frees packet buffer slots over a pool of fixed blocks.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on i_valid/o_ready as one beat of t_in_beat; each request
// gives exactly one result beat on o_valid/i_ready as t_out_beat.
// One request is in work at a time; o_ready is high only while idle.
// A free is decoded, its owner and slot checked and, if valid, its bitmap
// word read and bit checked. An allocate is decoded, then takes a class step
// per class tried; a class with free slots adds a downward scan that skips
// claimed blocks of other classes and reads each block of the class from the
// bitmap memory and checks it. Scans of all 32 owner entries for each of the
// three classes set the worst case; a fresh claim needs no scan.
// A new request is taken while the previous result still waits in the
// output register; the work then holds at its class, check or free step
// until the receiver takes that result.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata while the
// block is idle; the user must keep to this, the block does not enforce it.
// Reset restores the configuration, marks all blocks as unclaimed and clears counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_core import scsa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_beat   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_beat  o_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    scsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // State and result datapath.
    scsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data      (i_data),
        .o_data      (o_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // A result rises only after work with input closed.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without preceding work");

    // Waiters are woken only by a successful free.
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.wake_waiters |-> o_data.status == ST_OK)
        else $error("wake reported on a failed request");

    // A successful result never names the unclaimed owner code.
    a_class_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_OK |-> o_data.size_class != OWN_NONE)
        else $error("bad class on successful result");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator core testbench
// Drives allocate and free requests through the valid/ready handshake and
// checks each result beat against a cycle-free predictor of the allocator.
// Runs several register settings, including out-of-range size codes and
// block limits, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import scsa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 100;

    // Scoreboard: predicts the allocator state and holds the expected beats.
    class alloc_scoreboard;
        logic [3:0]  size_lg [NUM_CLASSES];
        logic [5:0]  blk_limit [NUM_CLASSES];
        logic [1:0]  owner [POOL_BLOCKS];
        logic [31:0] bitmap [POOL_BLOCKS];
        logic [5:0]  blk_free [POOL_BLOCKS];
        logic [10:0] cls_free [NUM_CLASSES];
        logic [5:0]  cls_blocks [NUM_CLASSES];
        logic [5:0]  next_blk;
        logic        waiting;
        t_out_beat   result_q [$];
        logic [14:0] live_q [$];
        int          mismatches;

        function new();
            size_lg[0] = 4'd5;
            size_lg[1] = 4'd7;
            size_lg[2] = 4'd9;
            blk_limit[0] = 6'd2;
            blk_limit[1] = 6'd6;
            blk_limit[2] = 6'd24;
            for (int i = 0; i < POOL_BLOCKS; i++) begin
                owner[i] = OWN_NONE;
                bitmap[i] = '0;
                blk_free[i] = '0;
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                cls_free[c] = '0;
                cls_blocks[c] = '0;
            end
            next_blk = '0;
            waiting = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [5:0] val);
            case (idx)
                CFG_C0_LOG2: size_lg[0] = val[3:0];
                CFG_C1_LOG2: size_lg[1] = val[3:0];
                CFG_C2_LOG2: size_lg[2] = val[3:0];
                CFG_C0_MAX:  blk_limit[0] = val;
                CFG_C1_MAX:  blk_limit[1] = val;
                CFG_C2_MAX:  blk_limit[2] = val;
                default: ;
            endcase
        endfunction

        function int eff_lg(int c);
            int lg;
            lg = size_lg[c];
            if (lg < 5) lg = 5;
            if (lg > 10) lg = 10;
            return lg;
        endfunction

        function int slot_count(int lg);
            int n;
            n = 1024 >> lg;
            if (n > SLOTS_MAX) n = SLOTS_MAX;
            return n;
        endfunction

        // Work out the result of one accepted request and update the state.
        function void note_request(t_in_beat b);
            t_out_beat r;
            int lg, n, blk, j, slot, own;
            r = '0;
            if (b.req_type) begin
                // Free: bad block owner, out-of-range slot or clear bit leaves everything as it is.
                r.status = ST_BADFREE;
                r.slot_address = b.free_address;
                blk = b.free_address >> BLOCK_LOG2;
                own = owner[blk];
                if (own != OWN_NONE) begin
                    r.size_class = own[1:0];
                    lg = eff_lg(own);
                    n = slot_count(lg);
                    slot = b.free_address[9:0] >> lg;
                    if (slot < n && bitmap[blk][slot]) begin
                        bitmap[blk][slot] = 1'b0;
                        if (blk_free[blk] != 6'h3F) blk_free[blk]++;
                        if (cls_free[own] != 11'h7FF) cls_free[own]++;
                        r.status = ST_OK;
                        r.wake_waiters = waiting;
                        waiting = 1'b0;
                    end
                end
                result_q.push_back(r);
                return;
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                lg = eff_lg(c);
                n = slot_count(lg);
                blk = POOL_BLOCKS;
                if ((1 << lg) < b.request_size) continue;
                if (cls_free[c] == 0) begin
                    if (cls_blocks[c] >= blk_limit[c] || next_blk >= POOL_BLOCKS) continue;
                    blk = next_blk;
                    next_blk++;
                    owner[blk] = 2'(c);
                    bitmap[blk] = '0;
                    blk_free[blk] = 6'(n);
                    cls_free[c] = (cls_free[c] + n > 2047) ? 11'h7FF : 11'(cls_free[c] + n);
                    if (cls_blocks[c] != 6'h3F) cls_blocks[c]++;
                end else begin
                    // Most recently claimed block of this class with a free slot.
                    for (int k = int'(next_blk) - 1; k >= 0; k--) begin
                        if (owner[k] == 2'(c) && blk_free[k] != 0) begin
                            blk = k;
                            break;
                        end
                    end
                    if (blk >= POOL_BLOCKS) continue;
                end
                for (j = 0; j < n; j++)
                    if (!bitmap[blk][j]) break;
                if (j >= n) continue;
                bitmap[blk][j] = 1'b1;
                if (blk_free[blk] != 0) blk_free[blk]--;
                if (cls_free[c] != 0) cls_free[c]--;
                r.status = ST_OK;
                r.slot_address = 15'(blk * 1024 + (j << lg));
                r.size_class = 2'(c);
                live_q.push_back(r.slot_address);
                result_q.push_back(r);
                return;
            end
            if (!b.no_wait) waiting = 1'b1;
            r.status = b.no_wait ? ST_NOSPACE : ST_WAIT;
            result_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation.
        function void check_result(t_out_beat got);
            t_out_beat want;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: unexpected result beat %h", got);
                return;
            end
            want = result_q.pop_front();
            if (got.status !== want.status || got.slot_address !== want.slot_address ||
                got.size_class !== want.size_class ||
                got.wake_waiters !== want.wake_waiters) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: status %0d/%0d addr %h/%h class %0d/%0d wake %0d/%0d",
                             want.status, got.status, want.slot_address, got.slot_address,
                             want.size_class, got.size_class, want.wake_waiters,
                             got.wake_waiters);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [5:0] i_cfg_wdata = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_beat   i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_beat  o_data;

    alloc_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    size_class_slab_allocator_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check accepted beats and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Send one request beat after a random idle gap and note it when taken.
    task automatic send_request(t_in_beat b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(b);
    endtask

    // Drain all results, let the block settle, then write all six registers.
    task automatic write_regs(logic [5:0] v0, logic [5:0] v1, logic [5:0] v2,
                              logic [5:0] v3, logic [5:0] v4, logic [5:0] v5);
        logic [5:0] vals [6];
        vals = '{v0, v1, v2, v3, v4, v5};
        i_valid <= 1'b0;
        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.set_reg(3'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_beat alloc_beat(int size, bit nw);
        t_in_beat b;
        b.req_type = 1'b0;
        b.request_size = 11'(size);
        b.no_wait = nw;
        b.free_address = 15'($urandom);
        return b;
    endfunction

    function automatic t_in_beat free_beat(logic [14:0] addr);
        t_in_beat b;
        b.req_type = 1'b1;
        b.request_size = 11'($urandom);
        b.no_wait = 1'($urandom);
        b.free_address = addr;
        return b;
    endfunction

    // Random traffic: allocations and frees, mostly of live slots, with some double and stray frees.
    task automatic random_items(int count);
        logic [14:0] addr;
        int pick;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(9) == 0)
                    send_request(alloc_beat($urandom_range(2047), 1'($urandom)));
                else
                    send_request(alloc_beat($urandom_range(1024), 1'($urandom)));
            end else begin
                pick = $urandom_range(9);
                if (sb.live_q.size() != 0 && pick < 7) begin
                    addr = sb.live_q[$urandom_range(sb.live_q.size() - 1)];
                    // Keep some live entries so that a later free is a double free.
                    if (pick < 6) begin
                        foreach (sb.live_q[k])
                            if (sb.live_q[k] == addr) begin
                                sb.live_q.delete(k);
                                break;
                            end
                    end
                    // Now and then an unaligned address inside the slot.
                    if (pick == 5) addr[4:0] = 5'($urandom);
                    send_request(free_beat(addr));
                end else begin
                    send_request(free_beat(15'($urandom)));
                end
            end
        end
    endtask

    initial begin
        logic [14:0] first_addr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings.
        write_regs(6'd5, 6'd7, 6'd9, 6'd2, 6'd6, 6'd24);
        send_request(free_beat(15'h7C00));
        send_request(alloc_beat(0, 1'b1));
        first_addr = sb.live_q[0];
        send_request(alloc_beat(1, 1'b0));
        send_request(alloc_beat(32, 1'b1));
        send_request(alloc_beat(33, 1'b1));
        send_request(alloc_beat(128, 1'b0));
        send_request(alloc_beat(129, 1'b1));
        send_request(alloc_beat(512, 1'b1));
        send_request(alloc_beat(513, 1'b1));
        send_request(alloc_beat(1024, 1'b1));
        send_request(alloc_beat(1025, 1'b1));
        send_request(alloc_beat(2047, 1'b0));
        send_request(free_beat(first_addr | 15'h001F));
        send_request(free_beat(first_addr));
        send_request(free_beat(15'h7FFF));
        send_request(alloc_beat(1024, 1'b0));
        send_request(free_beat(sb.live_q[1]));
        random_items(130);

        // Extremes: size codes below and above range, zero and full block limits.
        send_idle_pct = 87;
        write_regs(6'd0, 6'd15, 6'd10, 6'd0, 6'd32, 6'd32);
        random_items(150);

        stall_pct = 87;
        send_idle_pct = 0;
        write_regs(6'd8, 6'd6, 6'd5, 6'd63, 6'd1, 6'd3);
        random_items(150);

        stall_pct = 26;
        send_idle_pct = 26;
        write_regs(6'($urandom_range(15)), 6'($urandom_range(15)), 6'($urandom_range(15)),
                   6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)));
        random_items(150);

        i_valid <= 1'b0;
        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
